[src/lspc_pkg.sv]
// Shared constants, types and functions of the laser scan polar to Cartesian converter.
package lspc_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int RANGE_BITS     = 16;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int TURN_BITS      = 32;
  localparam int GATE_BITS      = (RANGE_BITS > CFG_BITS) ? RANGE_BITS : CFG_BITS;

  localparam int CORDIC_STEPS     = 31;
  localparam int CORDIC_PER_STAGE = 4;
  localparam int CORDIC_SLOTS     = 32;
  localparam int CORDIC_STAGES    = CORDIC_SLOTS / CORDIC_PER_STAGE;
  localparam int CORDIC_BITS      = 34;
  localparam int ROUND_SHIFT      = 30;

  localparam int PROD_BITS   = RANGE_BITS + 1 + CORDIC_BITS;
  localparam int PIPE_STAGES = CORDIC_STAGES + 3;

  localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctan(2^-i) as a fraction of a turn scaled by 2^32; the last slot is unused
  localparam logic signed [CORDIC_BITS-1:0] ATAN_TURNS [CORDIC_SLOTS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_ANGLE = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_RANGE_LOW   = 2'd2,
    REG_RANGE_HIGH  = 2'd3
  } lspc_reg_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range;
    logic                  point_valid;
    logic                  scan_end;
  } lspc_side_t;

  function automatic logic [ANGLE_BITS-1:0] sext_angle(input logic [CFG_BITS-1:0] v);
    logic signed [TURN_BITS-1:0] w;
    w = TURN_BITS'(signed'(v));
    return w[ANGLE_BITS-1:0];
  endfunction

  // round half away from zero, drop the Q2.30 fraction, saturate
  function automatic logic signed [RANGE_BITS:0] scale_round(
      input logic signed [PROD_BITS-1:0] p);
    logic [PROD_BITS-1:0] mag;
    logic [PROD_BITS-1:0] rnd;
    logic [PROD_BITS-1:0] lim;
    lim = {{(PROD_BITS-RANGE_BITS){1'b0}}, {RANGE_BITS{1'b1}}};
    mag = p[PROD_BITS-1] ? PROD_BITS'(-p) : PROD_BITS'(p);
    rnd = (mag + (PROD_BITS'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (rnd > lim) begin
      rnd = lim;
    end
    return p[PROD_BITS-1] ? -signed'(rnd[RANGE_BITS:0]) : signed'(rnd[RANGE_BITS:0]);
  endfunction

endpackage

[src/lspc_if.sv]
// Channel interfaces: beam samples in, Cartesian points out.
interface lspc_beam_if import lspc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_mm;
  logic                  range_finite;
  logic                  first_beam;
  logic                  last_beam;

  modport source(output valid, range_mm, range_finite, first_beam, last_beam, input ready);
  modport sink(input valid, range_mm, range_finite, first_beam, last_beam, output ready);
endinterface

interface lspc_point_if import lspc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [RANGE_BITS:0] x_mm;
  logic signed [RANGE_BITS:0] y_mm;
  logic                      point_valid;
  logic                      scan_end;

  modport source(output valid, x_mm, y_mm, point_valid, scan_end, input ready);
  modport sink(input valid, x_mm, y_mm, point_valid, scan_end, output ready);
endinterface

[src/lspc_front.sv]
// Configuration registers, beam angle tracking, range gate and input register.
module lspc_front import lspc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          accept,
  input  logic                          load,
  input  logic [RANGE_BITS-1:0]         range_mm,
  input  logic                          range_finite,
  input  logic                          first_beam,
  input  logic                          last_beam,
  output logic signed [CORDIC_BITS-1:0] z,
  output logic                          flip,
  output lspc_side_t                    side
);

  logic [ANGLE_BITS-1:0] start_angle;
  logic [ANGLE_BITS-1:0] angle_step;
  logic [CFG_BITS-1:0]   range_low;
  logic [CFG_BITS-1:0]   range_high;
  logic [ANGLE_BITS-1:0] beam_angle;
  logic [ANGLE_BITS-1:0] beam_angle_next;

  logic [ANGLE_BITS-1:0]        ang;
  logic [TURN_BITS-1:0]         turn;
  logic                         flip_next;
  logic signed [CORDIC_BITS-1:0] z_next;
  logic                         in_gate;
  lspc_side_t                   side_next;

  always_comb begin
    ang             = first_beam ? start_angle : beam_angle;
    beam_angle_next = ang + angle_step;
    turn            = {ang, {(TURN_BITS-ANGLE_BITS){1'b0}}};
    // second and third quadrant: rotate by a half turn, negate at the end
    flip_next       = turn[TURN_BITS-1] ^ turn[TURN_BITS-2];
    z_next          = CORDIC_BITS'(signed'({turn[TURN_BITS-1] ^ flip_next,
                                            turn[TURN_BITS-2:0]}));
    in_gate         = (GATE_BITS'(range_mm) >= GATE_BITS'(range_low)) &&
                      (GATE_BITS'(range_mm) <= GATE_BITS'(range_high));
    side_next.range       = range_mm;
    side_next.point_valid = range_finite && in_gate;
    side_next.scan_end    = last_beam;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= '0;
      angle_step  <= '0;
      range_low   <= '0;
      range_high  <= '1;
    end else if (cfg_we) begin
      unique case (lspc_reg_t'(cfg_index))
        REG_START_ANGLE: start_angle <= sext_angle(cfg_data);
        REG_ANGLE_STEP:  angle_step  <= sext_angle(cfg_data);
        REG_RANGE_LOW:   range_low   <= cfg_data;
        REG_RANGE_HIGH:  range_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle <= '0;
    end else if (accept) begin
      beam_angle <= beam_angle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      z    <= z_next;
      flip <= flip_next;
      side <= side_next;
    end
  end

endmodule

[src/lspc_cordic.sv]
// Pipelined rotation CORDIC giving cosine and sine in Q2.30.
module lspc_cordic import lspc_pkg::*; (
  input  logic                          clk,
  input  logic [CORDIC_STAGES-1:0]      en,
  input  logic signed [CORDIC_BITS-1:0] z_in,
  input  logic                          flip_in,
  input  lspc_side_t                    side_in,
  output logic signed [CORDIC_BITS-1:0] cos_v,
  output logic signed [CORDIC_BITS-1:0] sin_v,
  output lspc_side_t                    side_out
);

  logic signed [CORDIC_BITS-1:0] x_p [CORDIC_STAGES];
  logic signed [CORDIC_BITS-1:0] y_p [CORDIC_STAGES];
  logic signed [CORDIC_BITS-1:0] z_p [CORDIC_STAGES];
  logic                          flip_p [CORDIC_STAGES];
  lspc_side_t                    side_p [CORDIC_STAGES];

  logic signed [CORDIC_BITS-1:0] x_q [CORDIC_STAGES];
  logic signed [CORDIC_BITS-1:0] y_q [CORDIC_STAGES];
  logic signed [CORDIC_BITS-1:0] z_q [CORDIC_STAGES];
  logic                          flip_q [CORDIC_STAGES];
  lspc_side_t                    side_q [CORDIC_STAGES];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [CORDIC_BITS-1:0] xs;
    logic signed [CORDIC_BITS-1:0] ys;
    logic signed [CORDIC_BITS-1:0] zs;
    logic signed [CORDIC_BITS-1:0] dx;
    logic signed [CORDIC_BITS-1:0] dy;

    if (s == 0) begin : g_head
      assign x_p[s]    = CORDIC_GAIN;
      assign y_p[s]    = '0;
      assign z_p[s]    = z_in;
      assign flip_p[s] = flip_in;
      assign side_p[s] = side_in;
    end else begin : g_link
      assign x_p[s]    = x_q[s-1];
      assign y_p[s]    = y_q[s-1];
      assign z_p[s]    = z_q[s-1];
      assign flip_p[s] = flip_q[s-1];
      assign side_p[s] = side_q[s-1];
    end

    always_comb begin
      xs = x_p[s];
      ys = y_p[s];
      zs = z_p[s];
      dx = '0;
      dy = '0;
      for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
        if (s * CORDIC_PER_STAGE + k < CORDIC_STEPS) begin
          dx = ys >>> (s * CORDIC_PER_STAGE + k);
          dy = xs >>> (s * CORDIC_PER_STAGE + k);
          if (!zs[CORDIC_BITS-1]) begin
            xs = xs - dx;
            ys = ys + dy;
            zs = zs - ATAN_TURNS[s * CORDIC_PER_STAGE + k];
          end else begin
            xs = xs + dx;
            ys = ys - dy;
            zs = zs + ATAN_TURNS[s * CORDIC_PER_STAGE + k];
          end
        end
      end
      // undo the half-turn pre-rotation
      if (s == CORDIC_STAGES - 1 && flip_p[s]) begin
        xs = -xs;
        ys = -ys;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        x_q[s]    <= xs;
        y_q[s]    <= ys;
        z_q[s]    <= zs;
        flip_q[s] <= flip_p[s];
        side_q[s] <= side_p[s];
      end
    end
  end

  assign cos_v    = x_q[CORDIC_STAGES-1];
  assign sin_v    = y_q[CORDIC_STAGES-1];
  assign side_out = side_q[CORDIC_STAGES-1];

endmodule

[src/lspc_scale.sv]
// Range scaling: multiply, round, saturate and the output register.
module lspc_scale import lspc_pkg::*; (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [CORDIC_BITS-1:0] cos_v,
  input  logic signed [CORDIC_BITS-1:0] sin_v,
  input  lspc_side_t                    side_in,
  output logic signed [RANGE_BITS:0]    x_mm,
  output logic signed [RANGE_BITS:0]    y_mm,
  output logic                          point_valid,
  output logic                          scan_end
);

  logic signed [RANGE_BITS:0]    range_s;
  logic signed [PROD_BITS-1:0]   px;
  logic signed [PROD_BITS-1:0]   py;
  lspc_side_t                    side_m;

  assign range_s = signed'({1'b0, side_in.range});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px     <= range_s * cos_v;
      py     <= range_s * sin_v;
      side_m <= side_in;
    end
  end

  // zero the coordinates of a gated point
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_mm        <= side_m.point_valid ? scale_round(px) : '0;
      y_mm        <= side_m.point_valid ? scale_round(py) : '0;
      point_valid <= side_m.point_valid;
      scan_end    <= side_m.scan_end;
    end
  end

endmodule

[src/laser_scan_polar_to_cartesian.sv]
// Top level: laser range beams to Cartesian points.
//
//   channel  dir  word                                          handshake
//   beam     in   range_mm, range_finite, first_beam, last_beam  valid/ready
//   point    out  x_mm, y_mm, point_valid, scan_end              valid/ready
//   cfg      in   cfg_index, cfg_data                           cfg_we
//
// One word per cycle unless the output stalls. Input register, eight CORDIC
// stages of up to four micro-rotations, multiplier and output registers.
// Synchronous reset clears stage valids and beam angle, resets the config.
// Each stage holds only while it is full and the stage after it holds, so
// empty stages keep filling while a point waits at the output.
module laser_scan_polar_to_cartesian import lspc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  lspc_beam_if.sink                 beam,
  lspc_point_if.source              point
);

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] en;
  logic                   accept;

  logic signed [CORDIC_BITS-1:0] z0;
  logic                          flip0;
  lspc_side_t                    side0;
  logic signed [CORDIC_BITS-1:0] cos_v;
  logic signed [CORDIC_BITS-1:0] sin_v;
  lspc_side_t                    side_c;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || point.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign accept     = beam.valid && en[0];
  assign beam.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= beam.valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  lspc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .load         (en[0]),
    .range_mm     (beam.range_mm),
    .range_finite (beam.range_finite),
    .first_beam   (beam.first_beam),
    .last_beam    (beam.last_beam),
    .z            (z0),
    .flip         (flip0),
    .side         (side0)
  );

  lspc_cordic u_cordic (
    .clk      (clk),
    .en       (en[CORDIC_STAGES:1]),
    .z_in     (z0),
    .flip_in  (flip0),
    .side_in  (side0),
    .cos_v    (cos_v),
    .sin_v    (sin_v),
    .side_out (side_c)
  );

  lspc_scale u_scale (
    .clk         (clk),
    .en          (en[PIPE_STAGES-1:PIPE_STAGES-2]),
    .cos_v       (cos_v),
    .sin_v       (sin_v),
    .side_in     (side_c),
    .x_mm        (point.x_mm),
    .y_mm        (point.y_mm),
    .point_valid (point.point_valid),
    .scan_end    (point.scan_end)
  );

  assign point.valid = vld[PIPE_STAGES-1];

endmodule

[test/lspc_point_checker.sv]
`timescale 1ns / 1ps
// Watches the beam, point and register ports, predicts each point and compares.
module lspc_point_checker import lspc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  lspc_beam_if                      beam,
  lspc_point_if                     point,
  output int                        mismatches,
  output int                        points_owed
);

  typedef struct packed {
    logic signed [RANGE_BITS:0] x_mm;
    logic signed [RANGE_BITS:0] y_mm;
    logic                       point_valid;
    logic                       scan_end;
  } point_word_t;

  localparam int    ROTATIONS     = 31;
  localparam longint UNIT_PRESCALE = 652032874;

  // arctan(2^-i) in turns scaled by 2^32
  localparam longint ARCTAN_TURNS [ROTATIONS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1
  };

  logic [ANGLE_BITS-1:0] first_angle;
  logic [ANGLE_BITS-1:0] step_angle;
  logic [RANGE_BITS-1:0] gate_low;
  logic [RANGE_BITS-1:0] gate_high;
  logic [ANGLE_BITS-1:0] next_angle;
  point_word_t           owed_q[$];

  // cos and sin of a binary angle in Q2.30
  function automatic void unit_vector(input logic [ANGLE_BITS-1:0] ang,
                                      output longint c, output longint s);
    logic [31:0] turn;
    logic [31:0] shifted;
    logic        mirrored;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    turn = {ang, {(32-ANGLE_BITS){1'b0}}};
    shifted = turn + 32'h4000_0000;
    mirrored = shifted[31];
    // fold the left half plane onto the right one
    if (mirrored) begin
      turn = turn - 32'h8000_0000;
    end
    z = longint'($signed(turn));
    x = UNIT_PRESCALE;
    y = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_TURNS[i];
      end
    end
    c = mirrored ? -x : x;
    s = mirrored ? -y : y;
  endfunction

  // range times a Q2.30 factor, rounded half away from zero, saturated
  function automatic logic signed [RANGE_BITS:0] scaled_mm(input longint rng,
                                                           input longint factor);
    longint prod;
    longint mag;
    longint whole;
    longint ceiling;
    prod = rng * factor;
    mag = (prod < 0) ? -prod : prod;
    ceiling = (longint'(1) << RANGE_BITS) - 1;
    whole = (mag + (longint'(1) << 29)) >>> 30;
    if (whole > ceiling) begin
      whole = ceiling;
    end
    return (RANGE_BITS+1)'((prod < 0) ? -whole : whole);
  endfunction

  always @(posedge clk) begin : watch
    point_word_t           want;
    point_word_t           got;
    logic [ANGLE_BITS-1:0] ang;
    longint                c;
    longint                s;
    if (rst) begin
      first_angle = '0;
      step_angle = '0;
      gate_low = '0;
      gate_high = '1;
      next_angle = '0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (lspc_reg_t'(cfg_index))
          REG_START_ANGLE: first_angle = ANGLE_BITS'($signed(cfg_data));
          REG_ANGLE_STEP:  step_angle  = ANGLE_BITS'($signed(cfg_data));
          REG_RANGE_LOW:   gate_low    = RANGE_BITS'(cfg_data);
          REG_RANGE_HIGH:  gate_high   = RANGE_BITS'(cfg_data);
          default: ;
        endcase
      end
      if (beam.valid && beam.ready) begin
        ang = beam.first_beam ? first_angle : next_angle;
        next_angle = ang + step_angle;
        want.point_valid = beam.range_finite && beam.range_mm >= gate_low &&
                           beam.range_mm <= gate_high;
        want.scan_end = beam.last_beam;
        want.x_mm = '0;
        want.y_mm = '0;
        if (want.point_valid) begin
          unit_vector(ang, c, s);
          want.x_mm = scaled_mm(longint'(beam.range_mm), c);
          want.y_mm = scaled_mm(longint'(beam.range_mm), s);
        end
        owed_q.insert(owed_q.size(), want);
      end
      if (point.valid && point.ready) begin
        got = '{point.x_mm, point.y_mm, point.point_valid, point.scan_end};
        if (owed_q.size() == 0) begin
          $error("point word with no beam waiting for it: x_mm %0d y_mm %0d",
                 got.x_mm, got.y_mm);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (got.x_mm !== want.x_mm) begin
            $error("x_mm: expected %0d, got %0d", want.x_mm, got.x_mm);
            mismatches++;
          end
          if (got.y_mm !== want.y_mm) begin
            $error("y_mm: expected %0d, got %0d", want.y_mm, got.y_mm);
            mismatches++;
          end
          if (got.point_valid !== want.point_valid) begin
            $error("point_valid: expected %0b, got %0b", want.point_valid,
                   got.point_valid);
            mismatches++;
          end
          if (got.scan_end !== want.scan_end) begin
            $error("scan_end: expected %0b, got %0b", want.scan_end, got.scan_end);
            mismatches++;
          end
        end
      end
    end
    points_owed = owed_q.size();
  end

endmodule

[test/laser_scan_polar_to_cartesian_tb.sv]
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the polar to Cartesian converter.
module laser_scan_polar_to_cartesian_tb;
  import lspc_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int PIPE_LATENCY  = 11;
  localparam int PHASES        = 6;
  localparam int PHASE_BEAMS   = 150;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;
  int                        mismatches;
  int                        points_owed;
  int                        gap_pct;
  int                        stall_pct;
  int                        cycle_count = 0;
  logic [RANGE_BITS-1:0]     gate_lo;
  logic [RANGE_BITS-1:0]     gate_hi;

  lspc_beam_if  beam_ch();
  lspc_point_if point_ch();

  laser_scan_polar_to_cartesian u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .beam     (beam_ch),
    .point    (point_ch)
  );

  lspc_point_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .beam       (beam_ch),
    .point      (point_ch),
    .mismatches (mismatches),
    .points_owed(points_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // point receiver: stall at the rate of the current phase
  initial begin
    point_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      point_ch.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input lspc_reg_t idx, input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == REG_RANGE_LOW) begin
      gate_lo = value;
    end
    if (idx == REG_RANGE_HIGH) begin
      gate_hi = value;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // leaves valid high after the word is taken; the next call drops or reuses it
  task automatic send_beam(input logic [RANGE_BITS-1:0] rng, input logic finite,
                           input logic first, input logic last);
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      beam_ch.valid = 1'b0;
      @(negedge clk);
    end
    beam_ch.valid = 1'b1;
    beam_ch.range_mm = rng;
    beam_ch.range_finite = finite;
    beam_ch.first_beam = first;
    beam_ch.last_beam = last;
    do @(posedge clk); while (!beam_ch.ready);
  endtask

  task automatic drain_points();
    @(negedge clk);
    beam_ch.valid = 1'b0;
    while (points_owed != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 3) @(negedge clk);
  endtask

  function automatic logic [CFG_BITS-1:0] pick_angle(input logic fine);
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return fine ? CFG_BITS'($urandom_range(1, 400)) : 16'h0000;
      default: return CFG_BITS'($urandom);
    endcase
  endfunction

  // favor the gate edges and the extremes of the field
  function automatic logic [RANGE_BITS-1:0] pick_range();
    case ($urandom_range(11))
      0: return gate_lo;
      1: return gate_hi;
      2: return gate_lo - 1'b1;
      3: return gate_hi + 1'b1;
      4: return '1;
      5: return '0;
      default: return RANGE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int left;
    int beams;
    logic held;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_START_ANGLE;
    cfg_data = '0;
    beam_ch.valid = 1'b0;
    beam_ch.range_mm = '0;
    beam_ch.range_finite = 1'b0;
    beam_ch.first_beam = 1'b0;
    beam_ch.last_beam = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    gate_lo = '0;
    gate_hi = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no first beam since reset: angle starts at zero
    send_beam(16'd1000, 1'b1, 1'b0, 1'b0);
    send_beam(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_beam(16'd0, 1'b1, 1'b0, 1'b1);
    send_beam(16'hFFFF, 1'b0, 1'b1, 1'b1);

    // full circle in eighths, crossing the quarter turns and the wrap
    drain_points();
    write_reg(REG_START_ANGLE, 16'h4000);
    write_reg(REG_ANGLE_STEP, 16'h2000);
    for (int k = 0; k < 8; k++) begin
      send_beam(16'hFFFF, 1'b1, k == 0, k == 7);
    end

    // gate edges
    drain_points();
    write_reg(REG_START_ANGLE, 16'h8000);
    write_reg(REG_ANGLE_STEP, 16'h7FFF);
    write_reg(REG_RANGE_LOW, 16'd100);
    write_reg(REG_RANGE_HIGH, 16'd60000);
    send_beam(16'd99, 1'b1, 1'b1, 1'b0);
    send_beam(16'd100, 1'b1, 1'b0, 1'b0);
    send_beam(16'd60000, 1'b1, 1'b0, 1'b0);
    send_beam(16'd60001, 1'b1, 1'b0, 1'b0);
    send_beam(16'd30000, 1'b0, 1'b0, 1'b1);

    // empty gate: low above high
    drain_points();
    write_reg(REG_START_ANGLE, 16'h7FFF);
    write_reg(REG_ANGLE_STEP, 16'h8000);
    write_reg(REG_RANGE_LOW, 16'd5000);
    write_reg(REG_RANGE_HIGH, 16'd4000);
    send_beam(16'd4500, 1'b1, 1'b1, 1'b0);
    send_beam(16'd5000, 1'b1, 1'b0, 1'b0);
    send_beam(16'd4000, 1'b1, 1'b0, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_points();
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 75; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 75; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      write_reg(REG_START_ANGLE, pick_angle(1'b0));
      write_reg(REG_ANGLE_STEP, pick_angle(1'b1));
      case ($urandom_range(2))
        0: write_reg(REG_RANGE_LOW, 16'd0);
        1: write_reg(REG_RANGE_LOW, CFG_BITS'($urandom_range(0, 2000)));
        default: write_reg(REG_RANGE_LOW, CFG_BITS'($urandom));
      endcase
      case ($urandom_range(2))
        0: write_reg(REG_RANGE_HIGH, 16'hFFFF);
        1: write_reg(REG_RANGE_HIGH, CFG_BITS'($urandom_range(30000, 65535)));
        default: write_reg(REG_RANGE_HIGH, CFG_BITS'($urandom));
      endcase
      left = PHASE_BEAMS;
      held = 1'b0;
      while (left > 0) begin
        // hold the sender once per phase until the pipe is empty
        if (!held && left < PHASE_BEAMS / 2) begin
          drain_points();
          held = 1'b1;
        end
        if ($urandom_range(9) == 0) begin
          send_beam(RANGE_BITS'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
          left--;
        end else begin
          beams = $urandom_range(1, 40);
          for (int b = 0; b < beams; b++) begin
            send_beam(pick_range(), $urandom_range(15) != 0, b == 0, b == beams - 1);
          end
          left -= beams;
        end
      end
    end

    drain_points();
    repeat (PIPE_LATENCY * 2) @(negedge clk);
    if (points_owed != 0) begin
      $error("%0d expected points never arrived", points_owed);
    end
    if (mismatches == 0 && points_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[laser_scan_polar_to_cartesian.f]
src/lspc_pkg.sv
src/lspc_if.sv
src/lspc_front.sv
src/lspc_cordic.sv
src/lspc_scale.sv
src/laser_scan_polar_to_cartesian.sv
test/lspc_point_checker.sv
test/laser_scan_polar_to_cartesian_tb.sv
